>>> rtl/lobm_pkg.sv
// Shared types and codes for the limit order book matcher.
package lobm_pkg;

   localparam logic OP_PLACE  = 1'b0;
   localparam logic OP_CANCEL = 1'b1;

   localparam logic SIDE_BUY  = 1'b0;

   localparam logic [2:0] TYPE_GTC    = 3'd1;
   localparam logic [2:0] TYPE_POST   = 3'd2;
   localparam logic [2:0] TYPE_MARKET = 3'd4;

   localparam logic KIND_TRADE  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [2:0] ST_RESTED     = 3'd0;
   localparam logic [2:0] ST_DONE       = 3'd1;
   localparam logic [2:0] ST_CANCELLED  = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
   localparam logic [2:0] ST_LEVEL_FULL = 3'd4;
   localparam logic [2:0] ST_IGNORED    = 3'd5;

   typedef struct packed {
      logic        opcode;
      logic [31:0] order_id;
      logic        side;
      logic [2:0]  order_type;
      logic [7:0]  price_tick;
      logic [31:0] quantity;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] taker_id;
      logic [31:0] maker_id;
      logic [7:0]  trade_px;
      logic [31:0] trade_qty;
      logic [31:0] taker_remaining;
      logic [31:0] maker_remaining;
      logic [2:0]  status;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type rec;
   } eng_out_type;

endpackage

>>> rtl/limit_order_book_matcher.sv
// Top level of the price-time priority limit order book matcher.
//
//  channel | dir | handshake          | payload
//  req_    | in  | tvalid/tready      | tuser opcode, tdata order fields
//  rsp_    | out | tvalid/tready/last | tuser kind, tdata record fields
//
// After reset every level is swept to empty, with req_tready low. A place
// item reads each opposite level it visits and, per fill, the maker slot, then
// emits a trade record, bounded by the level memory and the slot memory read ports.
// A cancel walks the levels and their resting entries in order until it finds the
// id, then closes up each entry behind it. A result register parts the engine
// from rsp_; when rsp_tready holds low the engine waits on its record.
module limit_order_book_matcher import lobm_pkg::*; #(
   parameter int PRICE_LEVELS = 256,
   parameter int LEVEL_DEPTH  = 16,
   parameter int MAX_FILLS    = 63
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_tuser,   // opcode
   input  logic [79:0]  req_tdata,   // order_id, side, order_type, price_tick, quantity, pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic         rsp_tlast,
   output logic         rsp_tuser,   // kind
   output logic [175:0] rsp_tdata    // taker_id, maker_id, trade price, trade quantity,
                                     // taker_remaining, maker_remaining, status, pad
);

   req_type     item;
   eng_out_type eng_out;
   logic        out_free;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   // unpack the word, first field in the low bits
   assign item.opcode     = req_tuser;
   assign item.order_id   = req_tdata[31:0];
   assign item.side       = req_tdata[32];
   assign item.order_type = req_tdata[35:33];
   assign item.price_tick = req_tdata[43:36];
   assign item.quantity   = req_tdata[75:44];

   lobm_engine #(
      .PRICE_LEVELS(PRICE_LEVELS), .LEVEL_DEPTH(LEVEL_DEPTH), .MAX_FILLS(MAX_FILLS)
   ) u_engine (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .in_item(item), .out_free(out_free), .out(eng_out)
   );

   // load a new record whenever the output register drains or is empty
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= eng_out.valid;
      end
      if (out_free && eng_out.valid) begin
         rsp_ff <= eng_out.rec;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tdata  = {5'd0, rsp_ff.status, rsp_ff.maker_remaining, rsp_ff.taker_remaining,
                        rsp_ff.trade_qty, rsp_ff.trade_px, rsp_ff.maker_id, rsp_ff.taker_id};

endmodule

>>> rtl/lobm_ram.sv
// Single-port-write, single-port-read synchronous memory with registered read data.
module lobm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> rtl/lobm_engine.sv
// Matching sequencer: walks levels and order slots held in two memories.
module lobm_engine import lobm_pkg::*; #(
   parameter int PRICE_LEVELS = 256,
   parameter int LEVEL_DEPTH  = 16,
   parameter int MAX_FILLS    = 63
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  req_type     in_item,
   input  logic        out_free,
   output eng_out_type out
);

   localparam int NLVL = 2 * PRICE_LEVELS;
   localparam int LVW  = $clog2(NLVL);
   localparam int PB   = $clog2(PRICE_LEVELS);
   localparam int DB   = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
   localparam int CB   = $clog2(LEVEL_DEPTH + 1);
   localparam int NSLT = NLVL * LEVEL_DEPTH;
   localparam int SAW  = $clog2(NSLT);
   localparam int FW   = $clog2(MAX_FILLS + 1);
   localparam int LWW  = DB + CB;

   localparam logic [3:0] S_CLR   = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_MLVL  = 4'd2;
   localparam logic [3:0] S_MLW   = 4'd3;
   localparam logic [3:0] S_MSW   = 4'd4;
   localparam logic [3:0] S_MEMIT = 4'd5;
   localparam logic [3:0] S_MDONE = 4'd6;
   localparam logic [3:0] S_RW    = 4'd7;
   localparam logic [3:0] S_CLVL  = 4'd8;
   localparam logic [3:0] S_CLW   = 4'd9;
   localparam logic [3:0] S_CSW   = 4'd10;
   localparam logic [3:0] S_SHRD  = 4'd11;
   localparam logic [3:0] S_SHWR  = 4'd12;
   localparam logic [3:0] S_STAT  = 4'd13;

   function automatic logic [DB-1:0] pos_of(input logic [DB-1:0] head, input logic [CB-1:0] k);
      logic [DB:0] s;
      s = {1'b0, head} + (DB+1)'(k);
      if (s >= (DB+1)'(LEVEL_DEPTH)) begin
         s = s - (DB+1)'(LEVEL_DEPTH);
      end
      return DB'(s);
   endfunction

   function automatic logic [SAW-1:0] slot_addr(input logic [LVW-1:0] lvl,
                                                input logic [DB-1:0] pos);
      return SAW'(lvl) * SAW'(LEVEL_DEPTH) + SAW'(pos);
   endfunction

   logic [3:0]      state_ff, state_in;
   logic [LVW-1:0]  lvl_ff, lvl_in;
   logic [PB-1:0]   p_ff, p_in;
   logic [CB-1:0]   k_ff, k_in;
   logic [DB-1:0]   head_ff, head_in;
   logic [CB-1:0]   cnt_ff, cnt_in;
   logic [FW-1:0]   nfill_ff, nfill_in;
   logic [31:0]     id_ff, id_in;
   logic            side_ff, side_in;
   logic [2:0]      type_ff, type_in;
   logic [PB-1:0]   price_ff, price_in;
   logic [31:0]     rem_ff, rem_in;
   logic [31:0]     mid_ff, mid_in;
   logic [31:0]     mq_ff, mq_in;
   logic [31:0]     fq_ff, fq_in;
   logic [2:0]      st_ff, st_in;

   logic            lv_we, sl_we;
   logic [LVW-1:0]  lv_waddr, lv_raddr;
   logic [LWW-1:0]  lv_wdata, lv_rdata;
   logic [SAW-1:0]  sl_waddr, sl_raddr;
   logic [63:0]     sl_wdata, sl_rdata;

   logic [DB-1:0]   rd_head;
   logic [CB-1:0]   rd_cnt;
   logic [31:0]     rd_id, rd_qty, fill;
   logic [LVW-1:0]  opp_lvl;

   assign rd_head = lv_rdata[LWW-1:CB];
   assign rd_cnt  = lv_rdata[CB-1:0];
   assign rd_id   = sl_rdata[63:32];
   assign rd_qty  = sl_rdata[31:0];
   assign fill    = (rem_ff < rd_qty) ? rem_ff : rd_qty;
   assign opp_lvl = (side_ff == SIDE_BUY) ? LVW'(PRICE_LEVELS) + LVW'(p_ff) : LVW'(p_ff);

   lobm_ram #(.WIDTH(LWW), .DEPTH(NLVL)) u_level (
      .clock(clock), .wr_en(lv_we), .wr_addr(lv_waddr), .wr_data(lv_wdata),
      .rd_addr(lv_raddr), .rd_data(lv_rdata)
   );

   lobm_ram #(.WIDTH(64), .DEPTH(NSLT)) u_slot (
      .clock(clock), .wr_en(sl_we), .wr_addr(sl_waddr), .wr_data(sl_wdata),
      .rd_addr(sl_raddr), .rd_data(sl_rdata)
   );

   always_comb begin
      state_in = state_ff;
      lvl_in   = lvl_ff;
      p_in     = p_ff;
      k_in     = k_ff;
      head_in  = head_ff;
      cnt_in   = cnt_ff;
      nfill_in = nfill_ff;
      id_in    = id_ff;
      side_in  = side_ff;
      type_in  = type_ff;
      price_in = price_ff;
      rem_in   = rem_ff;
      mid_in   = mid_ff;
      mq_in    = mq_ff;
      fq_in    = fq_ff;
      st_in    = st_ff;
      lv_we    = 1'b0;
      lv_waddr = lvl_ff;
      lv_wdata = {head_ff, cnt_ff};
      lv_raddr = lvl_ff;
      sl_we    = 1'b0;
      sl_waddr = slot_addr(lvl_ff, pos_of(head_ff, k_ff));
      sl_wdata = sl_rdata;
      sl_raddr = slot_addr(lvl_ff, pos_of(head_ff, k_ff));
      in_ready = 1'b0;
      out      = '0;

      case (state_ff)
         S_CLR: begin
            // sweep every level back to empty
            lv_we    = 1'b1;
            lv_wdata = '0;
            lvl_in   = lvl_ff + 1'b1;
            if (lvl_ff == LVW'(NLVL - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               id_in    = in_item.order_id;
               side_in  = in_item.side;
               type_in  = in_item.order_type;
               price_in = PB'(in_item.price_tick);
               rem_in   = in_item.quantity;
               nfill_in = '0;
               p_in     = (in_item.side == SIDE_BUY) ? '0 : PB'(PRICE_LEVELS - 1);
               if (in_item.opcode == OP_CANCEL) begin
                  lvl_in   = '0;
                  state_in = S_CLVL;
               end else if (in_item.order_type != TYPE_GTC &&
                            in_item.order_type != TYPE_POST &&
                            in_item.order_type != TYPE_MARKET) begin
                  st_in    = ST_IGNORED;
                  state_in = S_STAT;
               end else if (32'(in_item.price_tick) >= 32'(PRICE_LEVELS)) begin
                  st_in    = ST_LEVEL_FULL;
                  state_in = S_STAT;
               end else if (in_item.order_type == TYPE_POST) begin
                  state_in = S_MDONE;
               end else begin
                  state_in = S_MLVL;
               end
            end
         end
         S_MLVL: begin
            lvl_in   = opp_lvl;
            lv_raddr = opp_lvl;
            if (rem_ff == '0 || nfill_ff == FW'(MAX_FILLS)) begin
               state_in = S_MDONE;
            end else begin
               state_in = S_MLW;
            end
         end
         S_MLW: begin
            head_in = rd_head;
            cnt_in  = rd_cnt;
            if (rd_cnt == '0) begin
               if (p_ff == price_ff) begin
                  state_in = S_MDONE;
               end else begin
                  p_in     = (side_ff == SIDE_BUY) ? p_ff + 1'b1 : p_ff - 1'b1;
                  state_in = S_MLVL;
               end
            end else begin
               sl_raddr = slot_addr(lvl_ff, rd_head);
               state_in = S_MSW;
            end
         end
         S_MSW: begin
            mid_in   = rd_id;
            fq_in    = fill;
            rem_in   = rem_ff - fill;
            mq_in    = rd_qty - fill;
            state_in = S_MEMIT;
         end
         S_MEMIT: begin
            out.valid               = 1'b1;
            out.rec.kind            = KIND_TRADE;
            out.rec.taker_id        = id_ff;
            out.rec.maker_id        = mid_ff;
            out.rec.trade_px        = 8'(p_ff);
            out.rec.trade_qty       = fq_ff;
            out.rec.taker_remaining = rem_ff;
            out.rec.maker_remaining = mq_ff;
            if (out_free) begin
               sl_we    = 1'b1;
               sl_waddr = slot_addr(lvl_ff, head_ff);
               sl_wdata = {mid_ff, mq_ff};
               if (mq_ff == '0) begin
                  // pop the filled maker off the level
                  lv_we    = 1'b1;
                  lv_wdata = {pos_of(head_ff, CB'(1)), cnt_ff - 1'b1};
               end
               nfill_in = nfill_ff + 1'b1;
               state_in = S_MLVL;
            end
         end
         S_MDONE: begin
            lvl_in   = (side_ff == SIDE_BUY) ? LVW'(price_ff)
                                             : LVW'(PRICE_LEVELS) + LVW'(price_ff);
            lv_raddr = lvl_in;
            if (type_ff == TYPE_MARKET || rem_ff == '0) begin
               st_in    = ST_DONE;
               state_in = S_STAT;
            end else begin
               state_in = S_RW;
            end
         end
         S_RW: begin
            state_in = S_STAT;
            if (32'(rd_cnt) >= 32'(LEVEL_DEPTH)) begin
               st_in = ST_LEVEL_FULL;
            end else begin
               sl_we    = 1'b1;
               sl_waddr = slot_addr(lvl_ff, pos_of(rd_head, rd_cnt));
               sl_wdata = {id_ff, rem_ff};
               lv_we    = 1'b1;
               lv_wdata = {rd_head, rd_cnt + 1'b1};
               st_in    = ST_RESTED;
            end
         end
         S_CLVL: begin
            state_in = S_CLW;
         end
         S_CLW: begin
            head_in = rd_head;
            cnt_in  = rd_cnt;
            k_in    = '0;
            if (rd_cnt == '0) begin
               if (lvl_ff == LVW'(NLVL - 1)) begin
                  rem_in   = '0;
                  st_in    = ST_NOT_FOUND;
                  state_in = S_STAT;
               end else begin
                  lvl_in   = lvl_ff + 1'b1;
                  state_in = S_CLVL;
               end
            end else begin
               sl_raddr = slot_addr(lvl_ff, rd_head);
               state_in = S_CSW;
            end
         end
         S_CSW: begin
            if (rd_id == id_ff) begin
               rem_in   = rd_qty;
               k_in     = k_ff + 1'b1;
               state_in = S_SHRD;
            end else if (k_ff + 1'b1 == cnt_ff) begin
               if (lvl_ff == LVW'(NLVL - 1)) begin
                  rem_in   = '0;
                  st_in    = ST_NOT_FOUND;
                  state_in = S_STAT;
               end else begin
                  lvl_in   = lvl_ff + 1'b1;
                  state_in = S_CLVL;
               end
            end else begin
               k_in     = k_ff + 1'b1;
               sl_raddr = slot_addr(lvl_ff, pos_of(head_ff, k_in));
            end
         end
         S_SHRD: begin
            // close up the gap one entry at a time
            if (k_ff < cnt_ff) begin
               state_in = S_SHWR;
            end else begin
               lv_we    = 1'b1;
               lv_wdata = {head_ff, cnt_ff - 1'b1};
               st_in    = ST_CANCELLED;
               state_in = S_STAT;
            end
         end
         S_SHWR: begin
            sl_we    = 1'b1;
            sl_waddr = slot_addr(lvl_ff, pos_of(head_ff, k_ff - 1'b1));
            k_in     = k_ff + 1'b1;
            state_in = S_SHRD;
         end
         S_STAT: begin
            out.valid               = 1'b1;
            out.rec.kind            = KIND_STATUS;
            out.rec.taker_id        = id_ff;
            out.rec.taker_remaining = rem_ff;
            out.rec.status          = st_ff;
            out.rec.last            = 1'b1;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         lvl_ff   <= '0;
         nfill_ff <= '0;
      end else begin
         state_ff <= state_in;
         lvl_ff   <= lvl_in;
         nfill_ff <= nfill_in;
      end
      p_ff     <= p_in;
      k_ff     <= k_in;
      head_ff  <= head_in;
      cnt_ff   <= cnt_in;
      id_ff    <= id_in;
      side_ff  <= side_in;
      type_ff  <= type_in;
      price_ff <= price_in;
      rem_ff   <= rem_in;
      mid_ff   <= mid_in;
      mq_ff    <= mq_in;
      fq_ff    <= fq_in;
      st_ff    <= st_in;
   end

   a_fill_cap: assert property (@(posedge clock) disable iff (reset)
      32'(nfill_ff) <= 32'(MAX_FILLS))
      else $error("fill count beyond cap");

   a_no_accept_while_emit: assert property (@(posedge clock) disable iff (reset)
      !(out.valid && in_ready))
      else $error("accepting while a record is pending");

   a_trade_resumes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MEMIT && out_free) |=> state_ff == S_MLVL)
      else $error("trade handoff did not resume matching");

endmodule

>>> bench/tb_limit_order_book_matcher.sv
// Self-checking bench for the limit order book matcher: directed rows, then random order flow.
module tb_limit_order_book_matcher;
   import lobm_pkg::*;

   localparam int PRICE_LEVELS = 256;
   localparam int LEVEL_DEPTH  = 16;
   localparam int MAX_FILLS    = 63;
   localparam int NUM_LEVELS   = 2 * PRICE_LEVELS;
   localparam int IDLE_LIMIT   = 60000;
   localparam int RANDOM_ITEMS = 160;

   // order types the block ignores
   localparam logic [2:0] TYPE_DAY     = 3'd0;
   localparam logic [2:0] TYPE_ICEBERG = 3'd3;
   localparam logic [2:0] TYPE_FAK     = 3'd5;
   localparam logic [2:0] TYPE_FOK     = 3'd6;
   localparam logic [2:0] TYPE_SPARE   = 3'd7;
   localparam logic       SIDE_SELL    = 1'b1;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic         req_tuser;   // opcode
   logic [79:0]  req_tdata;   // order_id, side, order_type, price_tick, quantity, pad
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic         rsp_tlast;
   logic         rsp_tuser;   // kind
   logic [175:0] rsp_tdata;   // taker_id, maker_id, trade price, trade quantity,
                              // taker_remaining, maker_remaining, status, pad

   limit_order_book_matcher #(
      .PRICE_LEVELS(PRICE_LEVELS),
      .LEVEL_DEPTH (LEVEL_DEPTH),
      .MAX_FILLS   (MAX_FILLS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      clock = 1'b1; #4;
      clock = 1'b0; #4;
   end

   // ---------------------------------------------------------------------
   // Book mirror: one FIFO of resting orders per side and price level.
   // Level index is side * PRICE_LEVELS + price, slots are ring buffers.
   // ---------------------------------------------------------------------
   logic [31:0] book_id  [NUM_LEVELS * LEVEL_DEPTH];
   logic [31:0] book_qty [NUM_LEVELS * LEVEL_DEPTH];
   bit          book_live[NUM_LEVELS * LEVEL_DEPTH];
   int          lvl_head [NUM_LEVELS];
   int          lvl_fill [NUM_LEVELS];

   rsp_type pending_records[$];   // records still owed by the block
   int      errors      = 0;
   int      trades_seen = 0;
   int      status_seen = 0;
   int      capped_runs = 0;
   int      words_sent  = 0;
   int      idle_cycles = 0;
   int      burst_left  = 0;

   function automatic int slot_of(int lvl, int k);
      return lvl * LEVEL_DEPTH + (lvl_head[lvl] + k) % LEVEL_DEPTH;
   endfunction

   function automatic rsp_type status_record(logic [31:0] id, logic [31:0] left,
                                             logic [2:0] st);
      rsp_type r;
      r = '0;
      r.kind            = KIND_STATUS;
      r.taker_id        = id;
      r.taker_remaining = left;
      r.status          = st;
      r.last            = 1'b1;
      return r;
   endfunction

   // Fill against one level, oldest order first, until it empties, the
   // taker runs dry or the per-item fill cap is hit.
   task automatic fill_level(input int lvl, input logic [7:0] px, input logic [31:0] id,
                             inout logic [31:0] left, inout rsp_type recs[$]);
      int      s;
      logic [31:0] q;
      rsp_type t;
      while (lvl_fill[lvl] > 0 && left != 0 && recs.size() < MAX_FILLS) begin
         s = slot_of(lvl, 0);
         q = (left < book_qty[s]) ? left : book_qty[s];
         left        -= q;
         book_qty[s] -= q;
         t = '0;
         t.kind            = KIND_TRADE;
         t.taker_id        = id;
         t.maker_id        = book_id[s];
         t.trade_px        = px;
         t.trade_qty       = q;
         t.taker_remaining = left;
         t.maker_remaining = book_qty[s];
         recs.insert(recs.size(), t);
         if (book_qty[s] == 0) begin
            book_live[s]  = 1'b0;
            lvl_head[lvl] = (lvl_head[lvl] + 1) % LEVEL_DEPTH;
            lvl_fill[lvl]--;
         end
      end
   endtask

   // Sweep the opposite side from its best price while it crosses the limit.
   task automatic sweep_book(input req_type r, inout logic [31:0] left,
                             inout rsp_type recs[$]);
      int opp;
      opp = (r.side == SIDE_BUY) ? PRICE_LEVELS : 0;
      if (r.side == SIDE_BUY) begin
         for (int p = 0; p <= int'(r.price_tick) && left != 0 && recs.size() < MAX_FILLS;
              p++)
            fill_level(opp + p, p[7:0], r.order_id, left, recs);
      end else begin
         for (int p = PRICE_LEVELS - 1; p >= int'(r.price_tick) && left != 0 &&
              recs.size() < MAX_FILLS; p--)
            fill_level(opp + p, p[7:0], r.order_id, left, recs);
      end
      if (recs.size() == MAX_FILLS)
         capped_runs++;
   endtask

   function automatic logic [2:0] rest_order(req_type r, logic [31:0] left);
      int lvl;
      int s;
      lvl = (r.side == SIDE_BUY ? 0 : PRICE_LEVELS) + r.price_tick;
      if (left == 0)
         return ST_DONE;
      if (lvl_fill[lvl] >= LEVEL_DEPTH)
         return ST_LEVEL_FULL;
      s = slot_of(lvl, lvl_fill[lvl]);
      book_id[s]   = r.order_id;
      book_qty[s]  = left;
      book_live[s] = 1'b1;
      lvl_fill[lvl]++;
      return ST_RESTED;
   endfunction

   // Remove the first live order with this id; close up the level behind it.
   function automatic logic cancel_order(logic [31:0] id, output logic [31:0] left);
      int s;
      int d;
      left = '0;
      for (int lvl = 0; lvl < NUM_LEVELS; lvl++) begin
         for (int k = 0; k < lvl_fill[lvl]; k++) begin
            s = slot_of(lvl, k);
            if (book_live[s] && book_id[s] == id) begin
               left = book_qty[s];
               for (int j = k + 1; j < lvl_fill[lvl]; j++) begin
                  d = slot_of(lvl, j - 1);
                  s = slot_of(lvl, j);
                  book_id[d]   = book_id[s];
                  book_qty[d]  = book_qty[s];
                  book_live[d] = book_live[s];
               end
               s = slot_of(lvl, lvl_fill[lvl] - 1);
               book_live[s] = 1'b0;
               book_id[s]   = '0;
               book_qty[s]  = '0;
               lvl_fill[lvl]--;
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   // Work out every record one accepted word causes and update the mirror.
   task automatic predict_book(input req_type r, output rsp_type recs[$]);
      logic [31:0] left;
      logic [2:0]  st;
      recs = {};
      left = r.quantity;
      if (r.opcode == OP_CANCEL) begin
         st = cancel_order(r.order_id, left) ? ST_CANCELLED : ST_NOT_FOUND;
      end else if (r.order_type == TYPE_GTC) begin
         sweep_book(r, left, recs);
         st = rest_order(r, left);
      end else if (r.order_type == TYPE_POST) begin
         st = rest_order(r, left);
      end else if (r.order_type == TYPE_MARKET) begin
         sweep_book(r, left, recs);
         st = ST_DONE;
      end else begin
         st = ST_IGNORED;
      end
      recs.insert(recs.size(), status_record(r.order_id, left, st));
   endtask

   // ---------------------------------------------------------------------
   // Sender: bursts of random length, random gaps between them.
   // ---------------------------------------------------------------------
   function automatic req_type order_word(logic op, logic [31:0] id, logic sd,
                                          logic [2:0] ty, logic [7:0] px, logic [31:0] qty);
      req_type r;
      r.opcode     = op;
      r.order_id   = id;
      r.side       = sd;
      r.order_type = ty;
      r.price_tick = px;
      r.quantity   = qty;
      return r;
   endfunction

   // Send one word; use the typed record if given, else the mirror's records.
   task automatic send_order(input req_type r, input bit typed, input rsp_type typed_rec);
      int      gap;
      rsp_type recs[$];
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= r.opcode;
      req_tdata  <= {4'b0, r.quantity, r.price_tick, r.order_type, r.side, r.order_id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_book(r, recs);
      if (typed) begin
         if (recs.size() != 1 || recs[0] != typed_rec) begin
            $error("directed row: book mirror disagrees with typed result for id %0d",
                   r.order_id);
            errors++;
         end
         pending_records.insert(pending_records.size(), typed_rec);
      end else begin
         foreach (recs[i]) pending_records.insert(pending_records.size(), recs[i]);
      end
      words_sent++;
   endtask

   task automatic send_checked(input req_type r);
      send_order(r, 1'b0, '0);
   endtask

   // ---------------------------------------------------------------------
   // Receiver stalls and record check.
   // ---------------------------------------------------------------------
   int stall_mode = 0;
   int stall_run  = 0;

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         idle_cycles <= 0;
      end else begin
         // switch stall pattern now and then: always ready, coin toss, long holds
         if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_run  = $urandom_range(20, 200);
         end
         stall_run--;
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 15) == 0);
         endcase

         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;

         if (rsp_tvalid && rsp_tready) begin
            got.kind            = rsp_tuser;
            got.taker_id        = rsp_tdata[31:0];
            got.maker_id        = rsp_tdata[63:32];
            got.trade_px        = rsp_tdata[71:64];
            got.trade_qty       = rsp_tdata[103:72];
            got.taker_remaining = rsp_tdata[135:104];
            got.maker_remaining = rsp_tdata[167:136];
            got.status          = rsp_tdata[170:168];
            got.last            = rsp_tlast;
            if (pending_records.size() == 0) begin
               $error("record with nothing expected: taker %0h kind %0b",
                      got.taker_id, got.kind);
               errors++;
            end else begin
               want = pending_records.pop_front();
               check_field("kind", want.kind, got.kind);
               check_field("taker_id", want.taker_id, got.taker_id);
               check_field("maker_id", want.maker_id, got.maker_id);
               check_field("trade_px", want.trade_px, got.trade_px);
               check_field("trade_qty", want.trade_qty, got.trade_qty);
               check_field("taker_remaining", want.taker_remaining, got.taker_remaining);
               check_field("maker_remaining", want.maker_remaining, got.maker_remaining);
               check_field("status", want.status, got.status);
               check_field("last", want.last, got.last);
               if (want.kind == KIND_TRADE) trades_seen++;
               else status_seen++;
            end
         end

         // watchdog: covers the reset sweep and a full cancel walk many times over
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Directed rows; expected record typed in where it is obvious.
   // ---------------------------------------------------------------------
   typedef struct {
      req_type word;
      bit      typed;
      rsp_type rec;
   } directed_row;

   directed_row rows[$];

   function automatic void add_row(directed_row d);
      rows.insert(rows.size(), d);
   endfunction

   function automatic directed_row plain_row(req_type w);
      directed_row d;
      d.word  = w;
      d.typed = 1'b0;
      d.rec   = '0;
      return d;
   endfunction

   function automatic directed_row typed_row(req_type w, logic [31:0] left, logic [2:0] st);
      directed_row d;
      d.word  = w;
      d.typed = 1'b1;
      d.rec   = status_record(w.order_id, left, st);
      return d;
   endfunction

   // random order, shaped to hit a narrow price band so orders cross
   function automatic req_type random_order();
      logic [31:0] id;
      logic [31:0] qty;
      logic [2:0]  ty;
      logic [7:0]  px;
      int          pick;
      id = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 40);
      if ($urandom_range(0, 99) < 15)
         return order_word(OP_CANCEL, id, 1'($urandom_range(0, 1)),
                           3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), $urandom);
      pick = $urandom_range(0, 99);
      if (pick < 40)      ty = TYPE_GTC;
      else if (pick < 65) ty = TYPE_POST;
      else if (pick < 82) ty = TYPE_MARKET;
      else                ty = 3'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (pick < 5)       qty = 32'hFFFF_FFFF - $urandom_range(0, 3);
      else if (pick < 8)  qty = 32'h0;
      else if (pick < 15) qty = $urandom;
      else                qty = $urandom_range(1, 100);
      px = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(100, 107));
      return order_word(OP_PLACE, id, 1'($urandom_range(0, 1)), ty, px, qty);
   endfunction

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = 1'b0;
      req_tdata  = '0;
      for (int i = 0; i < NUM_LEVELS * LEVEL_DEPTH; i++) begin
         book_id[i]   = '0;
         book_qty[i]  = '0;
         book_live[i] = 1'b0;
      end
      for (int i = 0; i < NUM_LEVELS; i++) begin
         lvl_head[i] = 0;
         lvl_fill[i] = 0;
      end

      // empty book: cancel misses, ignored types, zero quantity, extremes
      add_row(typed_row(order_word(OP_CANCEL, 32'd5, SIDE_BUY, TYPE_GTC, 8'd0, 32'd9),
                        32'd0, ST_NOT_FOUND));
      add_row(typed_row(order_word(OP_PLACE, 32'd6, SIDE_BUY, TYPE_DAY, 8'd3, 32'd7),
                        32'd7, ST_IGNORED));
      add_row(typed_row(order_word(OP_PLACE, 32'd7, SIDE_SELL, TYPE_ICEBERG, 8'd3,
                        32'd8), 32'd8, ST_IGNORED));
      add_row(typed_row(order_word(OP_PLACE, 32'd8, SIDE_BUY, TYPE_FAK, 8'd9, 32'd1),
                        32'd1, ST_IGNORED));
      add_row(typed_row(order_word(OP_PLACE, 32'd9, SIDE_SELL, TYPE_FOK, 8'd9, 32'd1),
                        32'd1, ST_IGNORED));
      add_row(typed_row(order_word(OP_PLACE, 32'hFFFF_FFFF, SIDE_SELL, TYPE_SPARE,
                        8'hFF, 32'hFFFF_FFFF), 32'hFFFF_FFFF, ST_IGNORED));
      add_row(typed_row(order_word(OP_PLACE, 32'd10, SIDE_BUY, TYPE_GTC, 8'd50, 32'd0),
                        32'd0, ST_DONE));
      add_row(typed_row(order_word(OP_PLACE, 32'd11, SIDE_SELL, TYPE_MARKET, 8'd0,
                        32'd40), 32'd40, ST_DONE));
      // resting orders at both price extremes
      add_row(typed_row(order_word(OP_PLACE, 32'd1, SIDE_BUY, TYPE_POST, 8'd0, 32'd1),
                        32'd1, ST_RESTED));
      add_row(typed_row(order_word(OP_PLACE, 32'hFFFF_FFFF, SIDE_SELL, TYPE_POST,
                        8'hFF, 32'hFFFF_FFFF), 32'hFFFF_FFFF, ST_RESTED));
      add_row(typed_row(order_word(OP_PLACE, 32'd2, SIDE_BUY, TYPE_POST, 8'd0, 32'd5),
                        32'd5, ST_RESTED));
      // post-only resting across the spread
      add_row(plain_row(order_word(OP_PLACE, 32'd3, SIDE_SELL, TYPE_POST, 8'd0, 32'd4)));
      // GTC buy at top sweeps the low sell, then the top sell, partially
      add_row(plain_row(order_word(OP_PLACE, 32'd12, SIDE_BUY, TYPE_GTC, 8'hFF,
                        32'd10)));
      // market sell down to zero takes both buys at level 0, FIFO order
      add_row(plain_row(order_word(OP_PLACE, 32'd13, SIDE_SELL, TYPE_MARKET, 8'd0,
                        32'd100)));
      // GTC sell that fully fills and does not rest
      add_row(plain_row(order_word(OP_PLACE, 32'd14, SIDE_BUY, TYPE_POST, 8'd20,
                        32'd6)));
      add_row(plain_row(order_word(OP_PLACE, 32'd15, SIDE_SELL, TYPE_GTC, 8'd20,
                        32'd6)));
      // duplicate ids, then cancel the first of them; cancel the top sell, then a miss
      add_row(plain_row(order_word(OP_PLACE, 32'd16, SIDE_BUY, TYPE_POST, 8'd30,
                        32'd2)));
      add_row(plain_row(order_word(OP_PLACE, 32'd16, SIDE_BUY, TYPE_POST, 8'd30,
                        32'd3)));
      add_row(plain_row(order_word(OP_CANCEL, 32'd16, SIDE_SELL, TYPE_DAY, 8'hFF,
                        32'hFFFF_FFFF)));
      add_row(plain_row(order_word(OP_CANCEL, 32'hFFFF_FFFF, SIDE_BUY, TYPE_GTC,
                        8'd0, 32'd0)));
      add_row(plain_row(order_word(OP_CANCEL, 32'd99, SIDE_BUY, TYPE_GTC, 8'd0, 32'd0)));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_order(rows[i].word, rows[i].typed, rows[i].rec);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 100) begin
            // fill four sell levels, overflow one, then sweep into the fill cap
            for (int lv = 0; lv < 4; lv++)
               for (int k = 0; k < LEVEL_DEPTH; k++)
                  send_checked(order_word(OP_PLACE, 32'(500 + lv * 16 + k), SIDE_SELL,
                                          TYPE_POST, 8'(200 + lv), 32'd1));
            send_checked(order_word(OP_PLACE, 32'd600, SIDE_SELL, TYPE_POST, 8'd200, 32'd1));
            send_checked(order_word(OP_PLACE, 32'd601, SIDE_BUY, TYPE_GTC, 8'd203, 32'd100));
            send_checked(order_word(OP_PLACE, 32'd602, SIDE_BUY, TYPE_MARKET, 8'hFF, 32'd5));
         end
         send_checked(random_order());
      end
      req_tvalid <= 1'b0;

      while (pending_records.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("sent %0d order words; checked %0d trades and %0d status records",
               words_sent, trades_seen, status_seen);
      $display("fill cap reached on %0d runs", capped_runs);
      if (errors == 0 && pending_records.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
